@@ hdl/wrt_pkg.sv @@
// ----------------------------------------------------------------------------
// wrt_pkg: shared types and constants for the worker reputation table
// Field widths, mode codes, register indexes and controller command types.
// ----------------------------------------------------------------------------
package wrt_pkg;

   localparam int MODE_W     = 3;
   localparam int SEV_W      = 12;
   localparam int CRED_W     = 32;
   localparam int THR_W      = 17;
   localparam int COOL_W     = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam int DEF_NUM_WORKERS = 64;
   localparam int DEF_TIME_BITS   = 48;

   localparam logic [MODE_W-1:0] MODE_ACCEPT   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_REJECT   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_MAYBE_BL = 3'd2;
   localparam logic [MODE_W-1:0] MODE_IS_BL    = 3'd3;

   localparam logic [CSR_IDX_W-1:0] REG_PRIOR_ALPHA = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PRIOR_BETA  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TRUSTED     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BLACKLIST   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_PENALTY = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_COOLDOWN    = 3'd5;

   localparam logic [CRED_W-1:0] ONE_Q8 = 32'd256;

   typedef struct packed {
      logic load;     // capture request, issue memory read
      logic exec;     // read data valid: compute products
      logic commit;   // write back and load result register
   } wrt_cmd_type;

   typedef struct packed {
      logic in_range;
   } wrt_status_type;

endpackage

@@ hdl/wrt_if.sv @@
// ----------------------------------------------------------------------------
// wrt_stream_if: valid/ready channel carrying a payload
// Generic handshake interface used for request, response and csr channels.
// ----------------------------------------------------------------------------
interface wrt_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/wrt_ram.sv @@
// ----------------------------------------------------------------------------
// wrt_ram: generic single-port RAM with registered read
// One address per cycle: the addressed word is read every cycle and written when we is set.
// ----------------------------------------------------------------------------
module wrt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

@@ hdl/wrt_ctrl.sv @@
// ----------------------------------------------------------------------------
// wrt_ctrl: request sequencer
// Walks each transaction through read, compute, write back and response.
// ----------------------------------------------------------------------------
module wrt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  wrt_pkg::wrt_status_type status,
   output wrt_pkg::wrt_cmd_type    cmd
);
   import wrt_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_READ = 5'b00010,
      S_EXEC = 5'b00100,
      S_WB   = 5'b01000,
      S_RSP  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = (state_ff == S_RSP);
   assign cmd.load   = req_valid && req_ready;
   // RAM read data lands in the cycle after the address is captured
   assign cmd.exec   = (state_ff == S_EXEC);
   assign cmd.commit = (state_ff == S_WB);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_READ;
         S_READ: state_in = S_EXEC;
         S_EXEC: state_in = S_WB;
         S_WB:   state_in = S_RSP;
         S_RSP:  if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   logic unused_ok;
   assign unused_ok = status.in_range;
endmodule

@@ hdl/wrt_dp.sv @@
// ----------------------------------------------------------------------------
// wrt_dp: reputation table datapath
// Entry storage, score compares and the update of one entry per transaction.
// ----------------------------------------------------------------------------
module wrt_dp #(
   parameter int NUM_WORKERS = wrt_pkg::DEF_NUM_WORKERS,
   parameter int TIME_BITS   = wrt_pkg::DEF_TIME_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  wrt_pkg::wrt_cmd_type          cmd,
   output wrt_pkg::wrt_status_type       status,
   input  logic [wrt_pkg::MODE_W-1:0]    in_mode,
   input  logic [5:0]                    in_worker,
   input  logic [wrt_pkg::SEV_W-1:0]     in_severity,
   input  logic                          in_spot,
   input  logic [TIME_BITS-1:0]          in_now,
   input  logic [15:0]                   prior_alpha,
   input  logic [15:0]                   prior_beta,
   input  logic [wrt_pkg::THR_W-1:0]     trusted_thr,
   input  logic [wrt_pkg::THR_W-1:0]     blacklist_thr,
   input  logic [wrt_pkg::SEV_W-1:0]     pen_cap,
   input  logic [wrt_pkg::COOL_W-1:0]    cooldown,
   output logic                          o_decision,
   output logic                          o_known,
   output logic [31:0]                   o_alpha,
   output logic [31:0]                   o_beta,
   output logic                          o_probation,
   output logic [31:0]                   o_accepted,
   output logic [31:0]                   o_rejected,
   output logic [31:0]                   o_spot_fail
);
   import wrt_pkg::*;

   localparam int AW  = $clog2(NUM_WORKERS);
   localparam int EW  = 5 * CRED_W + TIME_BITS + 1;
   localparam logic [TIME_BITS-1:0] TMAX = '1;

   // request capture
   logic [MODE_W-1:0]    mode_ff;
   logic [AW-1:0]        addr_ff;
   logic                 range_ff;
   logic [SEV_W-1:0]     sev_ff;
   logic                 spot_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic [NUM_WORKERS-1:0] valid_ff;

   logic in_range;
   assign in_range = ({26'd0, in_worker} < 32'(NUM_WORKERS));
   assign status.in_range = range_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= in_mode;
         addr_ff  <= AW'(in_worker);
         range_ff <= in_range;
         sev_ff   <= in_severity;
         spot_ff  <= in_spot;
         now_ff   <= in_now;
      end
   end

   // entry memory
   logic          we;
   logic [EW-1:0] wdata, rdata;
   wrt_ram #(.WIDTH(EW), .DEPTH(NUM_WORKERS)) u_ram (
      .clock(clock), .we(we), .addr(addr_ff), .wdata(wdata), .rdata(rdata)
   );

   // entry after touch
   logic                 valid_old, known;
   logic [31:0]          a0, b0, ac0, rc0, sc0;
   logic [TIME_BITS-1:0] bu0;
   logic                 pr0;
   assign valid_old = range_ff && valid_ff[addr_ff];
   always_comb begin
      if (valid_old) begin
         {a0, b0, ac0, rc0, sc0, bu0, pr0} = rdata;
      end else begin
         a0 = {16'd0, prior_alpha};
         b0 = {16'd0, prior_beta};
         ac0 = '0; rc0 = '0; sc0 = '0; bu0 = '0; pr0 = 1'b0;
      end
   end

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   // exec stage: next credits and products
   logic        upd;
   logic [31:0] a1, b1, ac1, rc1, sc1;
   logic [12:0] sev2;
   logic [SEV_W-1:0] sevc;
   assign upd = range_ff && (mode_ff <= MODE_IS_BL);
   assign known = upd || valid_old;
   always_comb begin
      a1 = a0; b1 = b0; ac1 = ac0; rc1 = rc0; sc1 = sc0;
      sev2 = spot_ff ? {sev_ff, 1'b0} : {1'b0, sev_ff};
      sevc = (sev2 > {1'b0, pen_cap}) ? pen_cap : sev2[SEV_W-1:0];
      if (upd && mode_ff == MODE_ACCEPT) begin
         ac1 = sat_add(ac0, 32'd1);
         a1  = sat_add(a0, ONE_Q8);
      end else if (upd && mode_ff == MODE_REJECT) begin
         rc1 = sat_add(rc0, 32'd1);
         if (spot_ff) sc1 = sat_add(sc0, 32'd1);
         b1 = sat_add(b0, {20'd0, sevc});
      end
   end

   logic [31:0] a_ff, b_ff, ac_ff, rc_ff, sc_ff;
   logic [TIME_BITS-1:0] bu_ff;
   logic pr_ff, known_ff;
   logic [32:0] sum_ff;
   logic [48:0] lhs_ff;
   logic [49:0] prod_t_ff, prod_b_ff;
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         a_ff <= a1; b_ff <= b1; ac_ff <= ac1; rc_ff <= rc1; sc_ff <= sc1;
         bu_ff <= bu0; pr_ff <= pr0; known_ff <= known;
         sum_ff <= {1'b0, a1} + {1'b0, b1};
         lhs_ff <= {1'b0, a1, 16'd0};
         prod_t_ff <= ({1'b0, a1} + {1'b0, b1}) * trusted_thr;
         prod_b_ff <= ({1'b0, a1} + {1'b0, b1}) * blacklist_thr;
      end
   end

   // write back stage
   logic trusted_ok, bl_ok;
   logic [TIME_BITS:0] until_w;
   logic [TIME_BITS-1:0] until_s, bu2;
   logic pr2, dec;
   assign trusted_ok = (sum_ff != '0) && ({1'b0, lhs_ff} >= prod_t_ff);
   assign bl_ok      = (sum_ff != '0) && ({1'b0, lhs_ff} >= prod_b_ff);
   assign until_w = {1'b0, now_ff} + (TIME_BITS+1)'(cooldown);
   assign until_s = until_w[TIME_BITS] ? TMAX : until_w[TIME_BITS-1:0];
   always_comb begin
      bu2 = bu_ff; pr2 = pr_ff; dec = 1'b0;
      if (upd) begin
         unique case (mode_ff)
            MODE_ACCEPT: if (pr_ff && trusted_ok) pr2 = 1'b0;
            MODE_REJECT: ;
            MODE_MAYBE_BL: if (bu_ff <= now_ff && !bl_ok) begin
               bu2 = until_s; dec = 1'b1;
            end
            default: if (bu_ff != '0) begin
               if (now_ff < bu_ff) dec = 1'b1;
               else begin bu2 = '0; pr2 = 1'b1; end
            end
         endcase
      end
   end

   assign we    = cmd.commit && upd;
   assign wdata = {a_ff, b_ff, ac_ff, rc_ff, sc_ff, bu2, pr2};

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (we) valid_ff[addr_ff] <= 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         o_decision  <= dec;
         o_known     <= known_ff;
         o_alpha     <= a_ff;
         o_beta      <= b_ff;
         o_probation <= known_ff && pr2;
         o_accepted  <= ac_ff;
         o_rejected  <= rc_ff;
         o_spot_fail <= sc_ff;
      end
   end
endmodule

@@ hdl/worker_reputation_table_core.sv @@
// ----------------------------------------------------------------------------
// worker_reputation_table_core: beta reputation table top level
// Channel  | dir | payload
// req_     | in  | mode, worker, severity, spot_hit, now_ms
// rsp_     | out | decision, known, alpha/beta, probation, counts
// csr_     | in  | index, value (six registers)
// Each transaction passes through capture, entry RAM read, score multiply,
// write back, then the response is held until taken. One transaction at a
// time, set by the read-modify-write of the single-port entry RAM.
// Reset clears entry valid bits and loads register defaults; no clear pass.
// A stalled response holds the sequencer; csr writes are always taken.
// ----------------------------------------------------------------------------
module worker_reputation_table_core #(
   parameter int NUM_WORKERS = wrt_pkg::DEF_NUM_WORKERS,
   parameter int TIME_BITS   = wrt_pkg::DEF_TIME_BITS
) (
   input  logic clock,
   input  logic reset,
   wrt_stream_if.sink   req,
   wrt_stream_if.source rsp,
   wrt_stream_if.sink   csr
);
   import wrt_pkg::*;

   logic [15:0]       pa_ff, pb_ff;
   logic [THR_W-1:0]  tt_ff, bt_ff;
   logic [SEV_W-1:0]  mp_ff;
   logic [COOL_W-1:0] cd_ff;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         pa_ff <= 16'd256; pb_ff <= 16'd256;
         tt_ff <= 17'd52429; bt_ff <= 17'd19661;
         mp_ff <= 12'd2048; cd_ff <= 32'd600000;
      end else if (csr.valid) begin
         unique case (csr.data.index)
            REG_PRIOR_ALPHA: pa_ff <= csr.data.value[15:0];
            REG_PRIOR_BETA:  pb_ff <= csr.data.value[15:0];
            REG_TRUSTED:     tt_ff <= csr.data.value[THR_W-1:0];
            REG_BLACKLIST:   bt_ff <= csr.data.value[THR_W-1:0];
            REG_MAX_PENALTY: mp_ff <= csr.data.value[SEV_W-1:0];
            REG_COOLDOWN:    cd_ff <= csr.data.value[COOL_W-1:0];
            default: ;
         endcase
      end
   end

   wrt_cmd_type    cmd;
   wrt_status_type status;

   wrt_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .status(status), .cmd(cmd)
   );

   wrt_dp #(.NUM_WORKERS(NUM_WORKERS), .TIME_BITS(TIME_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .in_mode(req.data.mode), .in_worker(req.data.worker),
      .in_severity(req.data.severity), .in_spot(req.data.spot_hit),
      .in_now(req.data.now_ms[TIME_BITS-1:0]),
      .prior_alpha(pa_ff), .prior_beta(pb_ff),
      .trusted_thr(tt_ff), .blacklist_thr(bt_ff),
      .pen_cap(mp_ff), .cooldown(cd_ff),
      .o_decision(rsp.data.decision), .o_known(rsp.data.known),
      .o_alpha(rsp.data.alpha_out), .o_beta(rsp.data.beta_out),
      .o_probation(rsp.data.probation_out),
      .o_accepted(rsp.data.accepted_out), .o_rejected(rsp.data.rejected_out),
      .o_spot_fail(rsp.data.spot_fail_out)
   );

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid)) else $error("request taken while response pending");
   a_rsp_after_wb: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp.valid) else $error("response missing after write back");
   a_decision_known: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.data.decision |-> rsp.data.known)
      else $error("decision on unknown worker");
endmodule
